// ===== sv/mtp_pkg.sv =====
package mtp_pkg;

    localparam int TIME_WIDTH  = 48;
    localparam int EVT_TIME_W  = 48;
    localparam int EVT_MSG_W   = 25;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] STATUS_META = 8'hFF;
    localparam logic [7:0] META_TEMPO  = 8'h51;
    localparam logic [7:0] META_EOT    = 8'h2F;
    localparam logic [7:0] DATA_MASK   = 8'h7F;
    localparam logic [3:0] NIB_SYSTEM  = 4'hF;
    localparam logic [3:0] NIB_PROGRAM = 4'hC;
    localparam logic [3:0] NIB_PRESSURE = 4'hD;
    localparam logic [31:0] TEMPO_LEN  = 32'd3;

    typedef enum logic [1:0] {
        KIND_CHANNEL   = 2'd0,
        KIND_TEMPO     = 2'd1,
        KIND_TRACK_END = 2'd2,
        KIND_ERROR     = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                   kind;
        logic [EVT_TIME_W-1:0]   time_val;
        logic [EVT_MSG_W-1:0]    msg;
    } t_event;

    typedef struct packed {
        logic   valid;
        t_event evt;
    } t_push;

    function automatic logic is_one_data(input logic [7:0] status);
        return status[7:4] == NIB_PROGRAM || status[7:4] == NIB_PRESSURE;
    endfunction

endpackage

// ===== sv/midi_track_event_parser.sv =====
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_ready   i_data_byte, i_chunk_end
// result    out        o_valid / i_ready   o_event_kind, o_event_time, o_event_msg
//
// One byte beat is taken per cycle while o_ready is high; a result appears on the output in the
// cycle after its byte at the earliest, later when older results are still waiting in the queue.
// Throughput is one byte per clock while o_ready is high; the parser state updates on each byte.
// A two-entry result queue separates the parser from the output side.
// o_ready drops while the queue holds two results, which needs an output stall first, and
// rises again in the cycle after a result leaves.
// Reset is synchronous and active low; the parser also clears itself after a chunk-end byte.
module midi_track_event_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_chunk_end,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [1:0]                       o_event_kind,
    output logic [mtp_pkg::EVT_TIME_W-1:0]   o_event_time,
    output logic [mtp_pkg::EVT_MSG_W-1:0]    o_event_msg
);
    import mtp_pkg::*;

    t_push  push;
    t_event evt;
    logic   room;

    mtp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_chunk_end (i_chunk_end),
        .i_room      (room),
        .o_push      (push)
    );

    mtp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_event (evt)
    );

    assign o_event_kind = evt.kind;
    assign o_event_time = evt.time_val;
    assign o_event_msg  = evt.msg;

    a_full_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("Input stalled while no result is pending.");

    a_plain_kinds_no_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_kind == KIND_ERROR || o_event_kind == KIND_TRACK_END)
        |-> o_event_msg == '0)
        else $error("Track end or error result carries a message.");

    a_tempo_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_event_msg[24] == (o_event_kind == KIND_TEMPO)))
        else $error("Tempo marker bit disagrees with the result kind.");

    a_result_follows_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_valid && o_ready) && !$past(o_valid) |-> !o_valid)
        else $error("Result appeared without an accepted beat.");

endmodule

// ===== sv/mtp_front.sv =====
module mtp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_data_byte,
    input  logic          i_chunk_end,
    input  logic          i_room,
    output mtp_pkg::t_push o_push
);
    import mtp_pkg::*;

    typedef enum logic [9:0] {
        PH_DELTA     = 10'b0000000001,
        PH_CMD       = 10'b0000000010,
        PH_DATA1     = 10'b0000000100,
        PH_DATA2     = 10'b0000001000,
        PH_META_TYPE = 10'b0000010000,
        PH_META_LEN  = 10'b0000100000,
        PH_SKIP      = 10'b0001000000,
        PH_TEMPO     = 10'b0010000000,
        PH_DONE      = 10'b0100000000,
        PH_ERROR     = 10'b1000000000
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [31:0]           r_delta, n_delta;
    logic [TIME_WIDTH-1:0] r_time, n_time;
    logic [7:0]            r_status, n_status;
    logic [23:0]           r_build, n_build;
    logic [7:0]            r_meta, n_meta;
    logic [31:0]           r_skip, n_skip;

    logic                  accept;
    logic [TIME_WIDTH-1:0] time_sum;
    logic [31:0]           delta_shift;
    logic [31:0]           skip_shift;
    logic [31:0]           skip_dec;
    logic                  res_valid;
    t_kind                 res_kind;
    logic [EVT_MSG_W-1:0]  res_msg;

    assign o_ready     = i_room;
    assign accept      = i_valid && i_room;
    assign time_sum    = r_time + TIME_WIDTH'(r_delta);
    assign delta_shift = {r_delta[24:0], 7'b0} + {24'b0, i_data_byte & DATA_MASK};
    assign skip_shift  = {r_skip[24:0], 7'b0} + {24'b0, i_data_byte & DATA_MASK};
    assign skip_dec    = r_skip - 32'd1;

    always_comb begin
        n_phase   = r_phase;
        n_delta   = r_delta;
        n_time    = r_time;
        n_status  = r_status;
        n_build   = r_build;
        n_meta    = r_meta;
        n_skip    = r_skip;
        res_valid = 1'b0;
        res_kind  = KIND_ERROR;
        res_msg   = '0;
        if (accept) begin
            unique case (r_phase)
                PH_DELTA: begin
                    n_delta = delta_shift;
                    if (i_data_byte[7]) begin
                        if (i_chunk_end) begin
                            res_valid = 1'b1;
                            n_phase   = PH_ERROR;
                        end
                    end else if (i_chunk_end) begin
                        res_valid = 1'b1;
                        if (delta_shift == 32'd0) begin
                            res_kind = KIND_TRACK_END;
                        end else begin
                            n_phase = PH_ERROR;
                        end
                    end else begin
                        n_phase = PH_CMD;
                    end
                end
                PH_CMD: begin
                    if (i_data_byte == STATUS_META) begin
                        if (i_chunk_end) begin
                            res_valid = 1'b1;
                            n_phase   = PH_ERROR;
                        end else begin
                            n_phase = PH_META_TYPE;
                        end
                    end else if (!i_data_byte[7]) begin
                        if (r_status == 8'd0) begin
                            res_valid = 1'b1;
                            n_phase   = PH_ERROR;
                        end else begin
                            n_build = {8'd0, i_data_byte, r_status};
                            if (is_one_data(r_status)) begin
                                res_valid = 1'b1;
                                res_kind  = KIND_CHANNEL;
                                res_msg   = {9'd0, i_data_byte, r_status};
                                n_time    = time_sum;
                                n_delta   = '0;
                                n_phase   = PH_DELTA;
                            end else if (i_chunk_end) begin
                                res_valid = 1'b1;
                                n_phase   = PH_ERROR;
                            end else begin
                                n_phase = PH_DATA2;
                            end
                        end
                    end else if (i_data_byte[7:4] != NIB_SYSTEM) begin
                        n_status = i_data_byte;
                        n_build  = {16'd0, i_data_byte};
                        if (i_chunk_end) begin
                            res_valid = 1'b1;
                            n_phase   = PH_ERROR;
                        end else begin
                            n_phase = PH_DATA1;
                        end
                    end else begin
                        res_valid = 1'b1;
                        n_phase   = PH_ERROR;
                    end
                end
                PH_DATA1: begin
                    n_build = {8'd0, i_data_byte, r_build[7:0]};
                    if (is_one_data(r_build[7:0])) begin
                        res_valid = 1'b1;
                        res_kind  = KIND_CHANNEL;
                        res_msg   = {9'd0, i_data_byte, r_build[7:0]};
                        n_time    = time_sum;
                        n_delta   = '0;
                        n_phase   = PH_DELTA;
                    end else if (i_chunk_end) begin
                        res_valid = 1'b1;
                        n_phase   = PH_ERROR;
                    end else begin
                        n_phase = PH_DATA2;
                    end
                end
                PH_DATA2: begin
                    n_build   = {i_data_byte, r_build[15:0]};
                    res_valid = 1'b1;
                    res_kind  = KIND_CHANNEL;
                    res_msg   = {1'b0, i_data_byte, r_build[15:0]};
                    n_time    = time_sum;
                    n_delta   = '0;
                    n_phase   = PH_DELTA;
                end
                PH_META_TYPE: begin
                    n_meta = i_data_byte;
                    n_skip = '0;
                    if (i_chunk_end) begin
                        res_valid = 1'b1;
                        n_phase   = PH_ERROR;
                    end else begin
                        n_phase = PH_META_LEN;
                    end
                end
                PH_META_LEN: begin
                    n_skip = skip_shift;
                    if (i_data_byte[7]) begin
                        if (i_chunk_end) begin
                            res_valid = 1'b1;
                            n_phase   = PH_ERROR;
                        end
                    end else if (r_meta == META_TEMPO) begin
                        if (skip_shift != TEMPO_LEN || i_chunk_end) begin
                            res_valid = 1'b1;
                            n_phase   = PH_ERROR;
                        end else begin
                            n_build = '0;
                            n_phase = PH_TEMPO;
                        end
                    end else begin
                        n_time  = time_sum;
                        n_delta = '0;
                        if (skip_shift == 32'd0) begin
                            n_phase = (r_meta == META_EOT) ? PH_DONE : PH_DELTA;
                            if (i_chunk_end) begin
                                res_valid = 1'b1;
                                res_kind  = KIND_TRACK_END;
                            end
                        end else if (i_chunk_end) begin
                            res_valid = 1'b1;
                            n_phase   = PH_ERROR;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    n_skip = skip_dec;
                    if (skip_dec == 32'd0) begin
                        n_phase = (r_meta == META_EOT) ? PH_DONE : PH_DELTA;
                        if (i_chunk_end) begin
                            res_valid = 1'b1;
                            res_kind  = KIND_TRACK_END;
                        end
                    end else if (i_chunk_end) begin
                        res_valid = 1'b1;
                        n_phase   = PH_ERROR;
                    end
                end
                PH_TEMPO: begin
                    n_build = {r_build[15:0], i_data_byte};
                    n_skip  = skip_dec;
                    if (skip_dec == 32'd0) begin
                        res_valid = 1'b1;
                        res_kind  = KIND_TEMPO;
                        res_msg   = {1'b1, r_build[15:0], i_data_byte};
                        n_time    = time_sum;
                        n_delta   = '0;
                        n_phase   = PH_DELTA;
                    end else if (i_chunk_end) begin
                        res_valid = 1'b1;
                        n_phase   = PH_ERROR;
                    end
                end
                PH_DONE: begin
                    if (i_chunk_end) begin
                        res_valid = 1'b1;
                        res_kind  = KIND_TRACK_END;
                    end
                end
                PH_ERROR: begin
                    n_phase = PH_ERROR;
                end
                default: begin
                    n_phase = PH_ERROR;
                end
            endcase
        end
    end

    // The reported time is the track time after this byte's update.
    always_comb begin
        o_push.valid        = res_valid;
        o_push.evt.kind     = res_kind;
        o_push.evt.time_val = EVT_TIME_W'(n_time);
        o_push.evt.msg      = res_msg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_chunk_end)) begin
            r_phase  <= PH_DELTA;
            r_delta  <= '0;
            r_time   <= '0;
            r_status <= '0;
            r_build  <= '0;
            r_meta   <= '0;
            r_skip   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_delta  <= n_delta;
            r_time   <= n_time;
            r_status <= n_status;
            r_build  <= n_build;
            r_meta   <= n_meta;
            r_skip   <= n_skip;
        end
    end

endmodule

// ===== sv/mtp_queue.sv =====
module mtp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mtp_pkg::t_push  i_push,
    output logic            o_room,
    output logic            o_valid,
    input  logic            i_ready,
    output mtp_pkg::t_event o_event
);
    import mtp_pkg::*;

    t_event            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              pop;

    assign o_room  = r_count != QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_event = r_mem[r_rd];
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr    = i_push.valid ? QPTR_W'(r_wr + 1'b1) : r_wr;
        n_rd    = pop ? QPTR_W'(r_rd + 1'b1) : r_rd;
        n_count = r_count + QCNT_W'(i_push.valid) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule
